>>> design/amdfs_pkg.sv
`default_nettype none

package amdfs_pkg;

    // Graph size and derived widths
    localparam int MAX_VERTICES = 32;
    localparam int RESULT_CAP   = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);
    localparam int CNT_W        = $clog2(RESULT_CAP + 1);

    // Fixed field widths
    localparam int NODE_W      = 5;
    localparam int CFG_W       = 6;
    localparam int LIVE_W      = CFG_W + 1;
    localparam int CFG_RESET   = 32;

    // Item function codes
    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_SEARCH   = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] vertex;
        logic              last;
        logic              error;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FINAL,
        S_ERROR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic write_edge;
        logic start_search;
        logic push;
        logic pop;
        logic emit_pending;
        logic emit_last;
        logic emit_error;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_func;
        logic item_error;
        logic stack_empty;
        logic cap_hit;
        logic open_any;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> design/amdfs_ctrl.sv
`default_nettype none

module amdfs_ctrl
    import amdfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.item_error)
                begin
                    state_next = S_ERROR;
                end
                else if (stat.item_func == FUNC_SEARCH)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.stack_empty || stat.cap_hit)
                begin
                    state_next = S_FINAL;
                end
            end
            S_FINAL,
            S_ERROR:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_DECODE:
            begin
                cmd.write_edge   = !stat.item_error && (stat.item_func == FUNC_ADD_EDGE);
                cmd.start_search = !stat.item_error && (stat.item_func == FUNC_SEARCH);
            end
            S_SCAN:
            begin
                if (!stat.stack_empty && !stat.cap_hit)
                begin
                    if (stat.open_any)
                    begin
                        // descend only when the previous vertex can leave
                        cmd.push         = stat.out_free;
                        cmd.emit_pending = stat.out_free;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                    end
                end
            end
            S_FINAL:
            begin
                cmd.emit_last = stat.out_free;
            end
            S_ERROR:
            begin
                cmd.emit_error = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/amdfs_dp.sv
`default_nettype none

module amdfs_dp
    import amdfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire in_item_t         in_data,
    input  wire logic             cfg_wen,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,
    input  wire dp_cmd_t          cmd,
    output dp_stat_t              stat
);

    in_item_t                 item_reg;
    logic [CFG_W-1:0]         vcount_reg;
    logic [MAX_VERTICES-1:0]  adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0]  visited_reg;
    logic [VIDX_W-1:0]        stack_reg [MAX_VERTICES];
    logic [DEPTH_W-1:0]       depth_reg;
    logic [VIDX_W-1:0]        top_reg;
    logic [VIDX_W-1:0]        pending_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic [LIVE_W-1:0]        live_n;
    logic [MAX_VERTICES-1:0]  live_mask;
    logic [MAX_VERTICES-1:0]  open_bits;
    logic [VIDX_W-1:0]        nxt;
    logic [VIDX_W-1:0]        a_idx;
    logic [VIDX_W-1:0]        b_idx;
    logic [DEPTH_W-1:0]       depth_below;
    logic                     can_push;
    logic                     out_free;

    assign a_idx = VIDX_W'(item_reg.node_a);
    assign b_idx = VIDX_W'(item_reg.node_b);

    // Limit the vertex count to the matrix size
    always_comb
    begin
        if (LIVE_W'(vcount_reg) > LIVE_W'(MAX_VERTICES))
        begin
            live_n = LIVE_W'(MAX_VERTICES);
        end
        else
        begin
            live_n = LIVE_W'(vcount_reg);
        end
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            live_mask[i] = LIVE_W'(i) < live_n;
        end
    end

    // Pick the lowest unvisited neighbor of the top vertex
    assign open_bits = adj_reg[top_reg] & live_mask & ~visited_reg;

    always_comb
    begin
        nxt = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (open_bits[i])
            begin
                nxt = VIDX_W'(i);
            end
        end
    end

    assign can_push    = depth_reg < DEPTH_W'(MAX_VERTICES);
    assign depth_below = depth_reg - DEPTH_W'(2);
    assign out_free    = !out_valid_reg || out_ready;

    // Status to the controller
    always_comb
    begin
        stat.item_func   = item_reg.func;
        stat.item_error  = (LIVE_W'(item_reg.node_a) >= live_n) ||
                           ((item_reg.func == FUNC_ADD_EDGE) &&
                            (LIVE_W'(item_reg.node_b) >= live_n));
        stat.stack_empty = depth_reg == '0;
        stat.cap_hit     = count_reg == CNT_W'(RESULT_CAP);
        stat.open_any    = |open_bits;
        stat.out_free    = out_free;
    end

    // Latch the item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
    end

    // Vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_W'(CFG_RESET);
        end
        else if (cfg_wen)
        begin
            vcount_reg <= cfg_wdata;
        end
    end

    // Adjacency matrix, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (cmd.write_edge)
        begin
            adj_reg[a_idx][b_idx] <= 1'b1;
            adj_reg[b_idx][a_idx] <= 1'b1;
        end
    end

    // Walk stack entries
    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            stack_reg[0] <= a_idx;
        end
        else if (cmd.push && can_push)
        begin
            stack_reg[depth_reg[VIDX_W-1:0]] <= nxt;
        end
    end

    // Search control: visited set, depth and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            depth_reg   <= '0;
            count_reg   <= '0;
        end
        else if (cmd.start_search)
        begin
            visited_reg <= MAX_VERTICES'(1) << a_idx;
            depth_reg   <= DEPTH_W'(1);
            count_reg   <= CNT_W'(1);
        end
        else if (cmd.push)
        begin
            visited_reg[nxt] <= 1'b1;
            count_reg        <= count_reg + CNT_W'(1);
            if (can_push)
            begin
                depth_reg <= depth_reg + DEPTH_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            depth_reg <= depth_reg - DEPTH_W'(1);
        end
    end

    // Track the top vertex and the vertex waiting to go out
    always_ff @(posedge clk)
    begin
        if (cmd.start_search)
        begin
            top_reg     <= a_idx;
            pending_reg <= a_idx;
        end
        else if (cmd.push)
        begin
            pending_reg <= nxt;
            if (can_push)
            begin
                top_reg <= nxt;
            end
        end
        else if (cmd.pop)
        begin
            top_reg <= stack_reg[depth_below[VIDX_W-1:0]];
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_pending || cmd.emit_last || cmd.emit_error)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_error)
        begin
            out_data_reg.vertex <= '0;
            out_data_reg.last   <= 1'b1;
            out_data_reg.error  <= 1'b1;
        end
        else if (cmd.emit_pending || cmd.emit_last)
        begin
            out_data_reg.vertex <= NODE_W'(pending_reg);
            out_data_reg.last   <= cmd.emit_last;
            out_data_reg.error  <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> design/adjacency_matrix_dfs_core.sv
`default_nettype none

// Depth-first search engine over a 32-vertex undirected graph held as an adjacency
// bit matrix (cleared at reset). An add-edge beat returns nothing; an out-of-range
// index returns one beat with error and last set. A search beat is decoded, then
// the walk descends to each vertex reached and backtracks from each, and finally
// flushes the last vertex; every step is a single neighbor pick (one matrix row read
// and a priority encode) in the datapath. Results go out through a one-beat output
// register; a stalled output holds each descent, while backtracking goes on.
// Vertices are emitted in preorder and the final one carries last. No clearing
// pass follows reset.
module adjacency_matrix_dfs_core
    import amdfs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,
    input  wire logic             cfg_wen,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    amdfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    amdfs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // One item at a time: an accepted beat closes the input for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item was in progress");

    // Descend only from a live stack and never over a waiting result
    a_push_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.stack_empty && stat.out_free && !stat.cap_hit)
        else $error("push issued without stack entry or output slot");

    // Error beats are final and carry vertex zero
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.last && (out_data.vertex == '0))
        else $error("malformed error beat");

endmodule

`default_nettype wire

>>> test/adjacency_matrix_dfs_core_tb.sv
module adjacency_matrix_dfs_core_tb;
    import amdfs_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_wen = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // Graph copy and vertex count used for prediction
    logic [MAX_VERTICES-1:0] graph_rows [MAX_VERTICES];
    int unsigned             live_n = CFG_RESET;

    in_item_t  pending_items [$];
    out_item_t walk_beats [$];

    // Idle control and statistics
    bit  idle_on = 1'b1;
    bit  long_hold_armed = 1'b0;
    int  tx_gap_left = 0;
    int  rx_stall_left = 0;
    int  rx_hold_left = 0;
    int  mismatches = 0;
    int  beats_checked = 0;
    int  searches_sent = 0;
    int  edges_sent = 0;
    int  errors_seen = 0;
    int  input_stall_cycles = 0;
    int  counts_written = 0;

    adjacency_matrix_dfs_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Work out the beats one item produces and update the graph copy
    task automatic predict_walk(input in_item_t item);
        logic [MAX_VERTICES-1:0] all_ones;
        logic [MAX_VERTICES-1:0] in_use;
        logic [MAX_VERTICES-1:0] seen;
        logic [MAX_VERTICES-1:0] open_set;
        logic [NODE_W-1:0]       path [$];
        logic [NODE_W-1:0]       top;
        logic [NODE_W-1:0]       nxt;
        out_item_t               held;
        int                      emitted;
        begin
            all_ones = '1;
            in_use = all_ones >> (MAX_VERTICES - live_n);
            held = '{vertex: '0, last: 1'b1, error: 1'b1};
            if (item.func == FUNC_ADD_EDGE) begin
                edges_sent++;
                if (item.node_a >= live_n || item.node_b >= live_n)
                begin
                    walk_beats.push_back(held);
                end
                else
                begin
                    graph_rows[item.node_a][item.node_b] = 1'b1;
                    graph_rows[item.node_b][item.node_a] = 1'b1;
                end
            end
            else if (item.node_a >= live_n)
            begin
                searches_sent++;
                walk_beats.push_back(held);
            end
            else
            begin
                searches_sent++;
                seen = '0;
                seen[item.node_a] = 1'b1;
                path.push_back(item.node_a);
                held = '{vertex: item.node_a, last: 1'b0, error: 1'b0};
                emitted = 1;
                while (path.size() > 0 && emitted < RESULT_CAP)
                begin
                    top = path[path.size() - 1];
                    open_set = graph_rows[top] & in_use & ~seen;
                    if (open_set == '0)
                    begin
                        void'(path.pop_back());
                    end
                    else
                    begin
                        // pick the lowest-numbered open neighbor
                        nxt = '0;
                        for (int i = MAX_VERTICES - 1; i >= 0; i--)
                            if (open_set[i])
                                nxt = NODE_W'(i);
                        seen[nxt] = 1'b1;
                        path.push_back(nxt);
                        walk_beats.push_back(held);
                        held = '{vertex: nxt, last: 1'b0, error: 1'b0};
                        emitted++;
                    end
                end
                held.last = 1'b1;
                walk_beats.push_back(held);
            end
        end
    endtask

    // Driver: offer pending items, with random idle bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_walk(in_data);
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (tx_gap_left > 0)
                begin
                    tx_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    tx_gap_left = $urandom_range(1, 16) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each output beat and drive ready with stalls
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (out_data.error)
                    errors_seen++;
                if (walk_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat vertex=%0d last=%0b error=%0b",
                                              out_data.vertex, out_data.last, out_data.error));
                end
                else
                begin
                    want = walk_beats.pop_front();
                    if (out_data.vertex !== want.vertex)
                        report_mismatch($sformatf("vertex %0d, expected %0d",
                                                  out_data.vertex, want.vertex));
                    if (out_data.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b (vertex %0d)",
                                                  out_data.last, want.last, want.vertex));
                    if (out_data.error !== want.error)
                        report_mismatch($sformatf("error %0b, expected %0b (vertex %0d)",
                                                  out_data.error, want.error, want.vertex));
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_armed)
            begin
                // hold off long enough for the block to back up into its input
                rx_hold_left = 400;
                long_hold_armed <= 1'b0;
                out_ready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left = $urandom_range(1, 16) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t mk_item(input logic func, input int a, input int b);
        in_item_t item;
        item.func   = func;
        item.node_a = NODE_W'(a);
        item.node_b = NODE_W'(b);
        return item;
    endfunction

    // Mostly in-range edges and searches, some out-of-range noise
    function automatic in_item_t rand_item(input int unsigned n);
        int unsigned r;
        int unsigned hi;
        r  = $urandom_range(0, 99);
        hi = (n == 0) ? 31 : n - 1;
        if (r < 62)
            return mk_item(FUNC_ADD_EDGE, $urandom_range(0, hi), $urandom_range(0, hi));
        else if (r < 72)
            return mk_item(FUNC_ADD_EDGE, $urandom_range(0, 31), $urandom_range(0, 31));
        else if (r < 92)
            return mk_item(FUNC_SEARCH, $urandom_range(0, hi), $urandom_range(0, 31));
        else
            return mk_item(FUNC_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31));
    endfunction

    // Wait until nothing is in flight, then let a possible edge write finish
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || walk_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int unsigned value);
        settle();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_wen <= 1'b0;
        live_n = (value > MAX_VERTICES) ? MAX_VERTICES : value;
        counts_written++;
    endtask

    task automatic queue_random(input int count);
        repeat (count)
            pending_items.push_back(rand_item(live_n));
    endtask

    // Stimulus
    initial
    begin
        foreach (graph_rows[i])
            graph_rows[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Empty graph, both index extremes, duplicates and a self loop
        pending_items.push_back(mk_item(FUNC_SEARCH, 0, 31));
        pending_items.push_back(mk_item(FUNC_SEARCH, 31, 0));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 0, 31));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 31, 0));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 5, 5));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 0, 1));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 1, 2));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 2, 3));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 1, 4));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 3, 0));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 4, 31));
        pending_items.push_back(mk_item(FUNC_SEARCH, 0, 0));
        pending_items.push_back(mk_item(FUNC_SEARCH, 5, 31));
        pending_items.push_back(mk_item(FUNC_SEARCH, 31, 31));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 31, 31));
        pending_items.push_back(mk_item(FUNC_SEARCH, 2, 17));

        // Shrunk count: out-of-range indices and stored edges left out of the walk
        set_vertex_count(3);
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 3, 0));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 0, 3));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 0, 2));
        pending_items.push_back(mk_item(FUNC_SEARCH, 3, 0));
        pending_items.push_back(mk_item(FUNC_SEARCH, 0, 0));
        pending_items.push_back(mk_item(FUNC_SEARCH, 2, 5));
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 31, 31));

        // Full graph with a long output hold-off while the sender keeps offering
        set_vertex_count(32);
        long_hold_armed <= 1'b1;
        pending_items.push_back(mk_item(FUNC_SEARCH, 0, 0));
        pending_items.push_back(mk_item(FUNC_SEARCH, 31, 0));
        pending_items.push_back(mk_item(FUNC_SEARCH, 4, 0));
        queue_random(60);

        set_vertex_count(1);
        pending_items.push_back(mk_item(FUNC_ADD_EDGE, 0, 0));
        queue_random(20);

        set_vertex_count(0);
        queue_random(10);

        set_vertex_count(63);
        queue_random(20);

        // Medium graph, with a pause until every result has drained
        set_vertex_count(12);
        queue_random(20);
        settle();
        queue_random(20);

        // Last part runs without idling on either side
        set_vertex_count(32);
        idle_on = 1'b0;
        queue_random(60);

        settle();
        repeat (20) @(posedge clk);
        $display("Covered %0d searches and %0d edge adds over %0d vertex-count writes;",
                 searches_sent, edges_sent, counts_written);
        $display("checked %0d output beats (%0d errors), input stalled %0d cycles.",
                 beats_checked, errors_seen, input_stall_cycles);
        if (mismatches == 0)
            $display("** adjacency_matrix_dfs_core: PASSED **");
        else
            $display("** adjacency_matrix_dfs_core: FAILED **");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("Timeout with %0d beats still expected", walk_beats.size());
        $display("** adjacency_matrix_dfs_core: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
design/amdfs_pkg.sv
design/amdfs_ctrl.sv
design/amdfs_dp.sv
design/adjacency_matrix_dfs_core.sv
test/adjacency_matrix_dfs_core_tb.sv
